[hw/rtl/tfn_pkg.sv]
// Shared types and constants for the triangle face normal core.
package tfn_pkg;

  // Number of vector components handled side by side.
  localparam int AXES = 3;

  // Fill status of the queue between the front and back sections.
  typedef struct packed {
    logic full;
    logic empty;
  } tfn_qstat_t;

endpackage

[hw/rtl/triangle_face_normal_core.sv]
// Top level of the triangle unit face normal core.
// Takes one triangle per transaction and returns its unit face normal in Q1.14,
// each component truncated toward zero; a zero-area triangle returns zeros with
// degenerate set. One triangle is accepted per cycle while results are taken.
// Between input and output lie three front stages for edges, cross product,
// squares and squared length, the queue, and one back stage per quotient
// bit. The queue lets the front keep accepting a few triangles while the
// output is stalled.
module triangle_face_normal_core
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         a_x,
  input  logic [COORD_BITS-1:0]         a_y,
  input  logic [COORD_BITS-1:0]         a_z,
  input  logic [COORD_BITS-1:0]         b_x,
  input  logic [COORD_BITS-1:0]         b_y,
  input  logic [COORD_BITS-1:0]         b_z,
  input  logic [COORD_BITS-1:0]         c_x,
  input  logic [COORD_BITS-1:0]         c_y,
  input  logic [COORD_BITS-1:0]         c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_x,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_y,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_z,
  output logic                          degenerate
);

  localparam int MW  = 2 * (COORD_BITS + 1);
  localparam int QSW = 2 * MW;
  localparam int SW  = QSW + 2;
  localparam int EWQ = SW + AXES * QSW + AXES;

  tfn_qstat_t      qstat;
  logic            push, pop;
  logic [SW-1:0]   f_len_sq, b_len_sq;
  logic [QSW-1:0]  f_comp_sq [AXES];
  logic [QSW-1:0]  b_comp_sq [AXES];
  logic [AXES-1:0] f_neg, b_neg;
  logic [EWQ-1:0]  wdata, rdata;

  tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_z      (c_z),
    .qstat    (qstat),
    .push     (push),
    .len_sq   (f_len_sq),
    .comp_sq  (f_comp_sq),
    .comp_neg (f_neg)
  );

  assign wdata = {f_len_sq, f_comp_sq[2], f_comp_sq[1], f_comp_sq[0], f_neg};

  tfn_queue #(.WIDTH(EWQ), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .qstat (qstat)
  );

  assign b_neg        = rdata[AXES-1:0];
  assign b_comp_sq[0] = rdata[AXES +: QSW];
  assign b_comp_sq[1] = rdata[AXES + QSW +: QSW];
  assign b_comp_sq[2] = rdata[AXES + 2 * QSW +: QSW];
  assign b_len_sq     = rdata[AXES + 3 * QSW +: SW];

  tfn_back #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .pop        (pop),
    .len_sq     (b_len_sq),
    .comp_sq    (b_comp_sq),
    .comp_neg   (b_neg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
  );

endmodule

[hw/rtl/tfn_front.sv]
// Front section: edges, cross product, squared components and squared length.
module tfn_front
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   a_x,
  input  logic [COORD_BITS-1:0]   a_y,
  input  logic [COORD_BITS-1:0]   a_z,
  input  logic [COORD_BITS-1:0]   b_x,
  input  logic [COORD_BITS-1:0]   b_y,
  input  logic [COORD_BITS-1:0]   b_z,
  input  logic [COORD_BITS-1:0]   c_x,
  input  logic [COORD_BITS-1:0]   c_y,
  input  logic [COORD_BITS-1:0]   c_z,
  input  tfn_qstat_t              qstat,
  output logic                    push,
  output logic [4*(COORD_BITS+1)+1:0]   len_sq,
  output logic [4*(COORD_BITS+1)-1:0]   comp_sq [AXES],
  output logic [AXES-1:0]         comp_neg
);

  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int QSW = 2 * MW;
  localparam int SW  = QSW + 2;

  logic signed [EW-1:0] e1 [AXES];
  logic signed [EW-1:0] e2 [AXES];
  logic signed [PW-1:0] pr [6];
  logic signed [NW-1:0] n_next [AXES];
  logic signed [NW-1:0] n [AXES];
  logic [NW-1:0]        mag_full [AXES];
  logic [QSW-1:0]       sq [AXES];
  logic [AXES-1:0]      neg2;
  logic                 v1, v2, v3;
  logic                 en;

  assign en       = !v3 || !qstat.full;
  assign in_ready = en;
  assign push     = v3;

  always_comb begin
    e1[0] = $signed({a_x[COORD_BITS-1], a_x}) - $signed({b_x[COORD_BITS-1], b_x});
    e1[1] = $signed({a_y[COORD_BITS-1], a_y}) - $signed({b_y[COORD_BITS-1], b_y});
    e1[2] = $signed({a_z[COORD_BITS-1], a_z}) - $signed({b_z[COORD_BITS-1], b_z});
    e2[0] = $signed({a_x[COORD_BITS-1], a_x}) - $signed({c_x[COORD_BITS-1], c_x});
    e2[1] = $signed({a_y[COORD_BITS-1], a_y}) - $signed({c_y[COORD_BITS-1], c_y});
    e2[2] = $signed({a_z[COORD_BITS-1], a_z}) - $signed({c_z[COORD_BITS-1], c_z});
    pr[0] = e1[1] * e2[2];
    pr[1] = e1[2] * e2[1];
    pr[2] = e1[2] * e2[0];
    pr[3] = e1[0] * e2[2];
    pr[4] = e1[0] * e2[1];
    pr[5] = e1[1] * e2[0];
    n_next[0] = NW'(pr[0]) - NW'(pr[1]);
    n_next[1] = NW'(pr[2]) - NW'(pr[3]);
    n_next[2] = NW'(pr[4]) - NW'(pr[5]);
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      mag_full[a] = n[a][NW-1] ? NW'(-n[a]) : NW'(n[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        n[a]  <= n_next[a];
        sq[a] <= mag_full[a][MW-1:0] * mag_full[a][MW-1:0];
        neg2[a] <= n[a][NW-1];
        comp_sq[a] <= sq[a];
      end
      comp_neg <= neg2;
      len_sq   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end
  end

endmodule

[hw/rtl/tfn_queue.sv]
// Small FIFO between the front and back sections.
module tfn_queue
  import tfn_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output tfn_qstat_t       qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rdata       = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/tfn_back.sv]
// Back section: bit-per-stage quotient search for each normal component.
module tfn_back
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tfn_qstat_t                    qstat,
  output logic                          pop,
  input  logic [4*(COORD_BITS+1)+1:0]   len_sq,
  input  logic [4*(COORD_BITS+1)-1:0]   comp_sq [AXES],
  input  logic [AXES-1:0]               comp_neg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_x,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_y,
  output logic [NORMAL_FRAC_BITS+1:0]   norm_z,
  output logic                          degenerate
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int MW  = 2 * (COORD_BITS + 1);
  localparam int QSW = 2 * MW;
  localparam int SW  = QSW + 2;
  localparam int PBW = SW + F + 1;
  localparam int DW  = SW + 2 * F + 3;
  localparam int QW  = F + 1;
  localparam int OW  = F + 2;

  // Per lane, d holds m^2 * 2^(2F) - q^2 * S and p holds q * S, so that
  // trying one more quotient bit needs only shifts, one add and one compare.
  logic [DW-1:0]   d_r  [F][AXES];
  logic [PBW-1:0]  p_r  [F][AXES];
  logic [QW-1:0]   q_r  [F+1][AXES];
  logic [SW-1:0]   s_r  [F+1];
  logic [AXES-1:0] sg_r [F+1];
  logic [F:0]      vld;
  logic            en;
  logic [OW-1:0]   res [AXES];

  assign en  = !vld[F] || out_ready;
  assign pop = en && !qstat.empty;

  for (genvar k = 0; k <= F; k++) begin : g_stage
    localparam int B = F - k;
    logic [DW-1:0]   d_in [AXES];
    logic [PBW-1:0]  p_in [AXES];
    logic [QW-1:0]   q_in [AXES];
    logic [SW-1:0]   s_in;
    logic [AXES-1:0] sg_in;
    logic            v_in;
    logic [DW-1:0]   t [AXES];
    logic [AXES-1:0] take;

    if (k == 0) begin : g_first
      always_comb begin
        s_in  = len_sq;
        sg_in = comp_neg;
        v_in  = !qstat.empty;
        for (int a = 0; a < AXES; a++) begin
          d_in[a] = DW'(comp_sq[a]) << (2 * F);
          p_in[a] = '0;
          q_in[a] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        s_in  = s_r[k-1];
        sg_in = sg_r[k-1];
        v_in  = vld[k-1];
        for (int a = 0; a < AXES; a++) begin
          d_in[a] = d_r[k-1][a];
          p_in[a] = p_r[k-1][a];
          q_in[a] = q_r[k-1][a];
        end
      end
    end

    always_comb begin
      for (int a = 0; a < AXES; a++) begin
        t[a]    = (DW'(p_in[a]) << (B + 1)) + (DW'(s_in) << (2 * B));
        take[a] = (t[a] <= d_in[a]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]  <= s_in;
        sg_r[k] <= sg_in;
        for (int a = 0; a < AXES; a++) begin
          q_r[k][a] <= q_in[a] | (take[a] ? (QW'(1) << B) : QW'(0));
        end
      end
    end

    if (k < F) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int a = 0; a < AXES; a++) begin
            d_r[k][a] <= take[a] ? d_in[a] - t[a] : d_in[a];
            p_r[k][a] <= take[a] ? p_in[a] + (PBW'(s_in) << B) : p_in[a];
          end
        end
      end
    end
  end

  always_comb begin
    degenerate = (s_r[F] == '0);
    for (int a = 0; a < AXES; a++) begin
      if (degenerate) begin
        res[a] = '0;
      end else if (sg_r[F][a]) begin
        res[a] = OW'(0) - OW'(q_r[F][a]);
      end else begin
        res[a] = OW'(q_r[F][a]);
      end
    end
  end

  assign out_valid = vld[F];
  assign norm_x    = res[0];
  assign norm_y    = res[1];
  assign norm_z    = res[2];

endmodule

[hw/rtl/tfn_checker.sv]
// Port-level assertions for the triangle face normal core, with its bind.
module tfn_checker #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [NORMAL_FRAC_BITS+1:0] norm_x,
  input logic [NORMAL_FRAC_BITS+1:0] norm_y,
  input logic [NORMAL_FRAC_BITS+1:0] norm_z,
  input logic                        degenerate
);

  localparam logic signed [NORMAL_FRAC_BITS+1:0] LIM = {2'b01, {NORMAL_FRAC_BITS{1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate result with nonzero components");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(norm_x) <= LIM && $signed(norm_x) >= -LIM &&
                  $signed(norm_y) <= LIM && $signed(norm_y) >= -LIM &&
                  $signed(norm_z) <= LIM && $signed(norm_z) >= -LIM)
    else $error("normal component beyond unit range");

endmodule

bind triangle_face_normal_core tfn_checker #(
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .norm_x     (norm_x),
  .norm_y     (norm_y),
  .norm_z     (norm_z),
  .degenerate (degenerate)
);
